/* hw/rtl/markov_index_to_password_defines.svh */
// assertion macros for the markov password generator
`ifndef MARKOV_INDEX_TO_PASSWORD_DEFINES_SVH
`define MARKOV_INDEX_TO_PASSWORD_DEFINES_SVH
`ifndef ASSERT_OFF
`define MIP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MIP_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MIP_ASSERT(label, clk, rst_n, prop, msg)
`define MIP_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/mip_pkg.sv */
`default_nettype none
package mip_pkg;
  localparam int unsigned MaxLenDef  = 16;
  localparam int unsigned CharsetDef = 256;
  localparam int unsigned MaxRankDef = 16;
  localparam int unsigned ThrDepth   = 16;

  localparam logic [1:0] ActWrThr = 2'd0;
  localparam logic [1:0] ActWrTab = 2'd1;
  localparam logic [1:0] ActGen   = 2'd2;

  localparam logic [1:0] RegMaxLength  = 2'd0;
  // byte address of the register
  localparam logic [1:0] AddrMaxLength = 2'(4 * RegMaxLength);

  // controller to datapath
  typedef struct packed {
    logic start;     // latch item, clear accumulators
    logic cum_step;  // one length-search step
    logic div_init;  // load local value for a position
    logic div_step;  // one divider step
    logic rd_issue;  // issue table read
    logic emit_load; // load output register with a char
    logic emit_nf;   // load output register with not-found
    logic next_pos;  // advance position
  } mip_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_thr;
    logic is_tab;
    logic is_gen;
    logic cum_done;
    logic not_found;
    logic div_done;
    logic last_pos;
  } mip_sts_t;
endpackage
`default_nettype wire

/* hw/rtl/markov_index_to_password.sv */
// markov_index_to_password: turns a 64-bit index into a password
//
// input channel (in_valid_i/in_ready_o) carries load and generate items.
// threshold and table loads give no result.
// a generate item searches the length one step a cycle (at most 16
// lengths), then extracts each character digit with a bit-serial
// restoring divider (64 steps), a registered table read and an emit;
// the one shared divider handles the characters one after another, the
// next divide starting only once the previous character is emitted.
// results leave through an output register (out_valid_o/out_ready_i),
// one per character with last_o on the final one; an index at or past
// the total gives one result with found_o low.
// a stalled receiver holds the output register and the sequencer waits
// in front of it; the next item is taken once the last result of the
// previous one sits in the output register.
// config: max_length at APB address 0, pready always high.
// reset clears the thresholds to all ones and max_length to 1; the
// character table is not cleared and holds garbage until written.
`default_nettype none
`include "markov_index_to_password_defines.svh"
module markov_index_to_password import mip_pkg::*; #(
  parameter int unsigned MaxLen  = MaxLenDef,
  parameter int unsigned Charset = CharsetDef,
  parameter int unsigned MaxRank = MaxRankDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [3:0]  position_i,
  input  wire logic [7:0]  prev_char_i,
  input  wire logic [3:0]  rank_i,
  input  wire logic [4:0]  threshold_value_i,
  input  wire logic [7:0]  table_char_i,
  input  wire logic [63:0] password_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  out_char_o,
  output logic      [3:0]  out_position_o,
  output logic             last_o,
  output logic             found_o
);
  logic [4:0] max_len_q;
  mip_cmd_t   cmd;
  mip_sts_t   sts;
  logic       last_q;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrMaxLength) ? {27'd0, max_len_q} : 32'd0;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_len_q <= 5'd1;
    else if (psel && penable && pwrite && paddr == AddrMaxLength)
      max_len_q <= pwdata[4:0];
  end

  // last flag alongside the output register
  always_ff @(posedge clk_i) begin
    if (cmd.emit_load) last_q <= sts.last_pos;
    else if (cmd.emit_nf) last_q <= 1'b1;
  end
  assign last_o = last_q;

  mip_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o (cmd), .sts_i (sts)
  );

  mip_dp #(.MaxLen(MaxLen), .Charset(Charset), .MaxRank(MaxRank)) u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .sts_o (sts), .max_length_i (max_len_q),
    .action_i, .position_i, .prev_char_i, .rank_i, .threshold_value_i,
    .table_char_i, .password_index_i, .out_char_o, .out_position_o, .found_o
  );

  `MIP_ASSERT(a_no_accept_busy, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")
  `MIP_ASSERT(a_emit_excl, clk_i, rst_ni, !(cmd.emit_load && cmd.emit_nf), "emit clash")
  `MIP_ASSERT(a_nf_last, clk_i, rst_ni, out_valid_o && !found_o |-> last_o, "not-found not last")
endmodule
`default_nettype wire

/* hw/rtl/mip_ram.sv */
`default_nettype none
module mip_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // single write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* hw/rtl/mip_ctrl.sv */
`default_nettype none
module mip_ctrl import mip_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output mip_cmd_t  cmd_o,
  input  mip_sts_t  sts_i
);
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StDec   = 7'b0000010,
    StCum   = 7'b0000100,
    StDiv   = 7'b0001000,
    StRead  = 7'b0010000,
    StEmit  = 7'b0100000,
    StWait  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;

  // sequencer: decode, length search, per-position divide, read, emit
  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = StDec;
        end
      end
      StDec: begin
        if (sts_i.is_gen) state_d = StCum;
        else state_d = StIdle;
      end
      StCum: begin
        if (sts_i.cum_done) begin
          if (sts_i.not_found) begin
            state_d = StWait;
          end else begin
            cmd_o.div_init = 1'b1;
            state_d = StDiv;
          end
        end else begin
          cmd_o.cum_step = 1'b1;
        end
      end
      StDiv: begin
        if (sts_i.div_done) begin
          cmd_o.rd_issue = 1'b1;
          state_d = StRead;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StRead: state_d = StWait;
      StEmit: begin
        cmd_o.next_pos = 1'b1;
        cmd_o.div_init = 1'b1;
        state_d = StDiv;
      end
      StWait: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          if (sts_i.not_found) begin
            cmd_o.emit_nf = 1'b1;
            state_d = StIdle;
          end else begin
            cmd_o.emit_load = 1'b1;
            state_d = sts_i.last_pos ? StIdle : StEmit;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/mip_dp.sv */
`default_nettype none
module mip_dp import mip_pkg::*; #(
  parameter int unsigned MaxLen  = MaxLenDef,
  parameter int unsigned Charset = CharsetDef,
  parameter int unsigned MaxRank = MaxRankDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  mip_cmd_t         cmd_i,
  output mip_sts_t         sts_o,
  input  wire logic [4:0]  max_length_i,
  input  wire logic [1:0]  action_i,
  input  wire logic [3:0]  position_i,
  input  wire logic [7:0]  prev_char_i,
  input  wire logic [3:0]  rank_i,
  input  wire logic [4:0]  threshold_value_i,
  input  wire logic [7:0]  table_char_i,
  input  wire logic [63:0] password_index_i,
  output logic      [7:0]  out_char_o,
  output logic      [3:0]  out_position_o,
  output logic             found_o
);
  localparam int unsigned Depth = MaxLen * Charset * MaxRank;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned BoundCap = (MaxLen < ThrDepth) ? MaxLen : ThrDepth;
  localparam logic [4:0] MaxRank5 = (MaxRank > 31) ? 5'd31 : 5'(MaxRank);
  localparam logic [4:0] BoundCap5 = 5'(BoundCap);

  // latched item
  logic [1:0]  act_q;
  logic [3:0]  pos_q;
  logic [7:0]  prv_q;
  logic [3:0]  rk_q;
  logic [4:0]  thv_q;
  logic [7:0]  tch_q;
  logic [63:0] idx_q;

  logic [4:0] thr_q [ThrDepth];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      act_q <= action_i;  pos_q <= position_i; prv_q <= prev_char_i;
      rk_q  <= rank_i;    thv_q <= threshold_value_i; tch_q <= table_char_i;
      idx_q <= password_index_i;
    end
  end

  logic in_range_tab;
  assign in_range_tab = (32'(pos_q) < MaxLen) && (32'(prv_q) < Charset)
                     && (32'(rk_q) < MaxRank);

  logic thr_we;
  assign thr_we = sts_o.is_thr && (32'(pos_q) < MaxLen);

  // threshold table, reset all ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ThrDepth; i++) thr_q[i] <= 5'h1f;
    end else if (thr_we) begin
      thr_q[pos_q] <= thv_q;
    end
  end

  logic dec_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dec_q <= 1'b0;
    else dec_q <= cmd_i.start;
  end
  assign sts_o.is_thr = dec_q && (act_q == ActWrThr);
  assign sts_o.is_tab = dec_q && (act_q == ActWrTab);
  assign sts_o.is_gen = dec_q && (act_q == ActGen);

  function automatic logic [4:0] radix(input logic [4:0] t);
    logic [4:0] r;
    r = (t == 5'd0) ? 5'd1 : t;
    if (r > MaxRank5) r = MaxRank5;
    return r;
  endfunction

  logic [4:0] bound;
  assign bound = (max_length_i > BoundCap5) ? BoundCap5 : max_length_i;

  // length search: one step per length
  logic [4:0]  len_q;
  logic [63:0] prod_q, cum_q, base_q;
  logic        srch_q, nf_q;
  logic [4:0]  rcum;
  logic [68:0] pmul;
  logic [63:0] pnext;
  logic [64:0] csum;
  logic [63:0] cnext;

  assign rcum  = radix(thr_q[len_q[3:0]]);
  assign pmul  = 69'(prod_q) * 69'(rcum);
  assign pnext = (pmul[68:64] != 5'd0) ? '1 : pmul[63:0];
  assign csum  = {1'b0, cum_q} + {1'b0, pnext};
  assign cnext = csum[64] ? '1 : csum[63:0];

  assign sts_o.cum_done  = !srch_q;
  assign sts_o.not_found = nf_q;

  // mixed-radix digit extraction by restoring division, one bit a step
  logic [63:0] rem_q, quo_q;
  logic [6:0]  dcnt_q;
  logic [4:0]  part_q;
  logic [3:0]  cpos_q;
  logic [7:0]  prev_q;
  logic [4:0]  rdiv;
  logic [5:0]  trial;
  logic [7:0]  ch;

  assign rdiv  = radix(thr_q[cpos_q]);
  assign trial = {part_q, rem_q[63]};
  assign sts_o.div_done = (dcnt_q == 7'd64);
  assign sts_o.last_pos = ({1'b0, cpos_q} + 5'd1 == len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srch_q <= 1'b0;
      nf_q   <= 1'b0;
    end else if (cmd_i.start) begin
      srch_q <= 1'b1;
      nf_q   <= 1'b0;
    end else if (cmd_i.cum_step) begin
      if (len_q >= bound) begin
        srch_q <= 1'b0;
        nf_q   <= 1'b1;
      end else if (idx_q < cnext) begin
        srch_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      len_q  <= 5'd0;
      prod_q <= 64'd1;
      cum_q  <= '0;
      base_q <= '0;
      cpos_q <= '0;
      prev_q <= '0;
    end
    if (cmd_i.cum_step && len_q < bound) begin
      prod_q <= pnext;
      cum_q  <= cnext;
      base_q <= cum_q;
      len_q  <= len_q + 5'd1;
    end
    if (cmd_i.next_pos) cpos_q <= cpos_q + 4'd1;
    if (cmd_i.emit_load) prev_q <= ch;
    if (cmd_i.div_init) begin
      rem_q  <= cmd_i.next_pos ? quo_q : (idx_q - (cmd_i.cum_step ? cum_q : base_q));
      dcnt_q <= '0;
      part_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + 7'd1;
      rem_q  <= {rem_q[62:0], (trial >= {1'b0, rdiv})};
      part_q <= (trial >= {1'b0, rdiv}) ? 5'(trial - {1'b0, rdiv}) : trial[4:0];
    end
    if (cmd_i.rd_issue) quo_q <= rem_q;
  end

  // table lookup
  logic [AW-1:0] raddr, waddr;
  logic [7:0]    rdata;
  logic          prv_ok;
  assign prv_ok = (32'(prev_q) < Charset);
  assign raddr = AW'(({32'(cpos_q)} * Charset + 32'(prev_q)) * MaxRank
                     + 32'(part_q));
  assign waddr = AW'((32'(pos_q) * Charset + 32'(prv_q)) * MaxRank + 32'(rk_q));

  mip_ram #(.Width(8), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (sts_o.is_tab && in_range_tab),
    .waddr_i (waddr),
    .wdata_i (tch_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic rdok_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) rdok_q <= prv_ok && (32'(part_q) < MaxRank);
  end

  assign ch = rdok_q ? rdata : 8'd0;

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_char_o     <= ch;
      out_position_o <= cpos_q;
      found_o        <= 1'b1;
    end else if (cmd_i.emit_nf) begin
      out_char_o     <= '0;
      out_position_o <= '0;
      found_o        <= 1'b0;
    end
  end
endmodule
`default_nettype wire
